// ===== design/mfd_pkg.sv =====
// Shared types and constants for the metering frame deframer.
// Used by the parser, the result queue, the result emitter and the top level.
package mfd_pkg;

  // Frame marks and header layout.
  localparam logic [7:0] START_MARK = 8'h68;
  localparam logic [7:0] END_MARK   = 8'h16;
  localparam int         HDR_BYTES  = 6;
  localparam int         LEN_W      = 14;
  localparam int         OFF_W      = 11;
  localparam int         ULEN_W     = 11;
  localparam int         CMP_W      = 16;

  // Index of the last header byte in a header burst.
  localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);

  // Verdict codes carried on the end byte's result.
  localparam logic [1:0] VERDICT_BUSY    = 2'd0;
  localparam logic [1:0] VERDICT_GOOD    = 2'd1;
  localparam logic [1:0] VERDICT_BAD_SUM = 2'd2;
  localparam logic [1:0] VERDICT_BAD_END = 2'd3;

  // One queue entry: either a whole header burst or one frame byte.
  typedef struct packed {
    logic                             hdr;
    logic [HDR_BYTES-1:0][7:0]        bytes;
    logic [OFF_W-1:0]                 offset;
    logic [ULEN_W-1:0]                ulen;
    logic                             fend;
    logic [1:0]                       verdict;
  } entry_t;

endpackage

// ===== design/mfd_front.sv =====
// Front part of the deframer: header hunt window, frame position and checksum.
// Classifies each received byte and pushes work entries; depends on mfd_pkg.
module mfd_front
  import mfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 2048
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   rx_byte,
  output logic         push,
  output entry_t       push_entry
);

  localparam int POS_W = $clog2(BUFFER_BYTES);

  logic [HDR_BYTES-1:0][7:0] window;
  logic [2:0]                window_fill;
  logic                      in_frame;
  logic [POS_W-1:0]          byte_position;
  logic [LEN_W-1:0]          frame_length;
  logic [7:0]                running_sum;

  logic [HDR_BYTES-1:0][7:0] window_next;
  logic [LEN_W-1:0]          l1;
  logic [LEN_W-1:0]          l2;
  logic                      window_full;
  logic                      hdr_ok;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          sum_end;
  logic                      in_body;
  logic                      at_check;
  logic [1:0]                end_verdict;

  // Window after this byte: fill from the front, then slide.
  always_comb begin
    window_next = window;
    if (window_fill < 3'(HDR_BYTES)) begin
      window_next[window_fill] = rx_byte;
    end else begin
      for (int k = 0; k < HDR_BYTES - 1; k++) begin
        window_next[k] = window[k+1];
      end
      window_next[HDR_BYTES-1] = rx_byte;
    end
  end

  // Header check on the updated window; the low two bits of each length are markers.
  assign l1 = LEN_W'({window_next[2], window_next[1]} >> 2);
  assign l2 = LEN_W'({window_next[4], window_next[3]} >> 2);
  assign window_full = (window_fill >= 3'(HDR_BYTES - 1));
  assign hdr_ok = window_full &&
                  (window_next[0] == START_MARK) && (window_next[HDR_BYTES-1] == START_MARK) &&
                  (l1 == l2) && (l1 != '0) &&
                  ((CMP_W'(l1) + CMP_W'(8)) <= CMP_W'(BUFFER_BYTES));

  // Position class within a frame.
  assign pos_ext  = CMP_W'(byte_position);
  assign sum_end  = CMP_W'(frame_length) + CMP_W'(6);
  assign in_body  = (pos_ext < sum_end);
  assign at_check = (pos_ext == sum_end);

  always_comb begin
    if (rx_byte != END_MARK) begin
      end_verdict = VERDICT_BAD_END;
    end else if (running_sum != 8'd0) begin
      end_verdict = VERDICT_BAD_SUM;
    end else begin
      end_verdict = VERDICT_GOOD;
    end
  end

  // Entry pushed for this byte.
  always_comb begin
    push_entry          = '0;
    push_entry.bytes    = window_next;
    push_entry.ulen     = ULEN_W'(l1);
    push_entry.verdict  = VERDICT_BUSY;
    push                = 1'b0;
    if (in_frame) begin
      push                = take;
      push_entry.hdr      = 1'b0;
      push_entry.bytes    = '0;
      push_entry.bytes[0] = rx_byte;
      push_entry.offset   = OFF_W'(byte_position);
      push_entry.ulen     = ULEN_W'(frame_length);
      if (!in_body && !at_check) begin
        push_entry.fend    = 1'b1;
        push_entry.verdict = end_verdict;
      end
    end else begin
      push           = take && hdr_ok;
      push_entry.hdr = 1'b1;
    end
  end

  // Window storage is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (take && !in_frame) begin
      window <= window_next;
    end
  end

  // Frame tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill   <= '0;
      in_frame      <= 1'b0;
      byte_position <= '0;
      frame_length  <= '0;
      running_sum   <= '0;
    end else if (take) begin
      if (in_frame) begin
        if (in_body) begin
          running_sum   <= running_sum + rx_byte;
          byte_position <= byte_position + 1'b1;
        end else if (at_check) begin
          running_sum   <= running_sum - rx_byte;
          byte_position <= byte_position + 1'b1;
        end else begin
          in_frame      <= 1'b0;
          window_fill   <= '0;
          byte_position <= '0;
          running_sum   <= '0;
        end
      end else if (hdr_ok) begin
        in_frame      <= 1'b1;
        frame_length  <= l1;
        byte_position <= POS_W'(HDR_BYTES);
        running_sum   <= '0;
        window_fill   <= '0;
      end else if (window_fill < 3'(HDR_BYTES)) begin
        window_fill <= window_fill + 1'b1;
      end
    end
  end

endmodule

// ===== design/mfd_queue.sv =====
// Short queue of work entries between the deframer's front and back parts.
// Register-based storage with head and tail pointers; depends on mfd_pkg.
module mfd_queue
  import mfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign not_empty  = (count != '0);
  assign head_entry = slots[head];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_entry;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/mfd_back.sv =====
// Back part of the deframer: expands queue entries into results.
// A header entry becomes six results; holds the output register; depends on mfd_pkg.
module mfd_back
  import mfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              have_entry,
  input  entry_t            entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        data_byte,
  output logic [OFF_W-1:0]  offset,
  output logic [ULEN_W-1:0] user_length,
  output logic              frame_end,
  output logic [1:0]        verdict,
  output logic              last
);

  logic [2:0] burst_idx;
  logic       load;
  logic       burst_done;

  assign load       = have_entry && (!out_valid || out_ready);
  assign burst_done = (burst_idx == HDR_LAST);
  assign pop        = load && (!entry.hdr || burst_done);

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      user_length <= entry.ulen;
      frame_end   <= entry.fend;
      verdict     <= entry.verdict;
      if (entry.hdr) begin
        data_byte <= entry.bytes[burst_idx];
        offset    <= OFF_W'(burst_idx);
        last      <= burst_done;
      end else begin
        data_byte <= entry.bytes[0];
        offset    <= entry.offset;
        last      <= 1'b1;
      end
    end
  end

  // Output valid and header burst counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      burst_idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load && entry.hdr) begin
        burst_idx <= burst_done ? '0 : burst_idx + 1'b1;
      end
    end
  end

endmodule

// ===== design/meter_frame_deframer.sv =====
// Metering frame deframer: hunts for a 0x68 / L1 / L2 / 0x68 header in a byte
// stream and passes each frame byte on with its offset, user length and end verdict.
//
// Input channel: rx_byte with in_valid / in_ready, one byte per transfer.
// Output channel: data_byte, offset, user_length, frame_end, verdict and last
// with out_valid / out_ready, one result per transfer.
// The queue is written at the transfer of the byte that causes a result, and
// the output register is loaded from the queue once it is free or taken.
// Throughput: one byte per cycle inside a frame and while hunting, while the
// queue has room. A valid header yields six results at once and the result
// emitter gives one result per cycle while the receiver takes them, so the
// queue can fill behind a header, and in_ready then drops until it has room.
// Reset: rst is synchronous and active high; it empties the queue and the
// output register and restarts the hunt with an empty header window.
// Receiver stall: results wait in the output register and queue; when the
// queue is full in_ready goes low until the receiver takes results again.
// After an end byte, good or not, hunting restarts with the next byte.
module meter_frame_deframer
  import mfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 2048,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        data_byte,
  output logic [OFF_W-1:0]  offset,
  output logic [ULEN_W-1:0] user_length,
  output logic              frame_end,
  output logic [1:0]        verdict,
  output logic              last
);

  logic   take;
  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   not_empty;
  entry_t head_entry;

  // Bytes are taken whenever the queue has room.
  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  mfd_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_entry(push_entry)
  );

  mfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_entry(head_entry)
  );

  mfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .have_entry (not_empty),
    .entry      (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .offset     (offset),
    .user_length(user_length),
    .frame_end  (frame_end),
    .verdict    (verdict),
    .last       (last)
  );

endmodule
